@@ design/deq_pkg.sv @@
// shared types, constants and helpers for the deque with remove-by-value
`timescale 1ns / 1ps
package deq_pkg;

	// sizing
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int SUM_W     = CNT_W + 1;

	// port field widths
	localparam int FUNC_W = 3;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCNT_W = 5;

	// request codes
	localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] F_REMOVE     = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  removed_value;
		logic [OCNT_W-1:0] entry_count;
		logic              is_empty;
	} result_t;

	// circular add, base below DEPTH and offset at most DEPTH
	function automatic ptr_t ptr_add(ptr_t base, cnt_t off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return PTR_W'(sum);
	endfunction

	// circular decrement
	function automatic ptr_t ptr_dec(ptr_t base);
		ptr_t r;
		if (base == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = base - PTR_W'(1);
		end
		return r;
	endfunction

	// port value to stored word, zero extended or truncated
	function automatic word_t to_word(logic [VAL_W-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[WORD_BITS-1:0];
	endfunction

	// stored word to port value
	function automatic logic [VAL_W-1:0] to_port(word_t w);
		logic [63:0] t;
		t = 64'(w);
		return t[VAL_W-1:0];
	endfunction

endpackage

@@ design/deque_with_remove_by_value.sv @@
// top level of the bounded deque with remove-by-value
`timescale 1ns / 1ps
// Bounded deque of up to 16 words kept in one memory with a registered read
// port, addressed as a ring from a head pointer. One request is worked at a
// time: a push goes from accept straight to the result state, a pop passes
// first through a read state, and a remove by value through a scan state,
// since the single read port walks the entries from the front, one a cycle,
// comparing and then moving each entry behind the match down by one. The
// result waits in an output register, so the next request is accepted while
// it is still untaken. Every request gives exactly one result transaction.
module deque_with_remove_by_value (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value [31:0]
	input  logic [2:0]  s_tuser,   // func [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status [1:0], removed_value [33:2],
	                               // entry_count [38:34], is_empty [39]
);
	import deq_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;
	result_t out_res;

	// request sequencer and memory
	deq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_func  (s_tuser),
		.req_value (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result register
	deq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.is_empty, out_res.entry_count,
	                  out_res.removed_value, out_res.status};

	// result fields agree with each other
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_res.entry_count <= OCNT_W'(DEPTH)))
		else $error("entry count above depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_res.is_empty == (out_res.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_res.status == STAT_FULL))
		|-> (out_res.entry_count == OCNT_W'(DEPTH)))
		else $error("full status below depth");

	a_fail_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_res.status != STAT_OK)) |-> (out_res.removed_value == '0))
		else $error("refused request returned a word");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_res.status == STAT_EMPTY)) |-> out_res.is_empty)
		else $error("empty status with entries held");

endmodule

@@ design/deq_engine.sv @@
// request sequencer with the circular word memory
`timescale 1ns / 1ps
module deq_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [deq_pkg::FUNC_W-1:0]  req_func,
	input  logic [deq_pkg::VAL_W-1:0]   req_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output deq_pkg::result_t            res
);
	import deq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0]        state_q;
	ptr_t              head_q;
	cnt_t              cnt_q;
	word_t             key_q;
	word_t             removed_q;
	logic [STAT_W-1:0] status_q;
	logic              found_q;
	cnt_t              rd_pos_q;
	logic              val_s1;
	cnt_t              pos_s1;
	word_t             rd_data_q;
	word_t             mem [DEPTH];

	logic  accept;
	logic  full;
	logic  empty;
	word_t in_word;
	logic  mem_we;
	ptr_t  mem_waddr;
	word_t mem_wdata;
	logic  mem_re;
	ptr_t  mem_raddr;
	logic  match;
	logic  last;

	assign accept  = req_valid && (state_q == S_IDLE);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign in_word = to_word(req_value);
	assign match   = val_s1 && !found_q && (rd_data_q == key_q);
	assign last    = val_s1 && (pos_s1 == cnt_q - CNT_W'(1));

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = in_word;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		if (accept) begin
			unique case (req_func)
				F_PUSH_FRONT: begin
					mem_we    = !full;
					mem_waddr = ptr_dec(head_q);
				end
				F_PUSH_BACK: begin
					mem_we    = !full;
					mem_waddr = ptr_add(head_q, cnt_q);
				end
				F_POP_FRONT: begin
					mem_re    = !empty;
					mem_raddr = head_q;
				end
				F_POP_BACK: begin
					mem_re    = !empty;
					mem_raddr = ptr_add(head_q, cnt_q - CNT_W'(1));
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SCAN) begin
			// read the next position, move entries past the match down by one
			mem_re    = (rd_pos_q < cnt_q);
			mem_raddr = ptr_add(head_q, rd_pos_q);
			mem_we    = val_s1 && found_q;
			mem_waddr = ptr_add(head_q, pos_s1 - CNT_W'(1));
			mem_wdata = rd_data_q;
		end
	end

	// word memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			cnt_q     <= '0;
			key_q     <= '0;
			removed_q <= '0;
			status_q  <= STAT_OK;
			found_q   <= 1'b0;
			rd_pos_q  <= '0;
			val_s1    <= 1'b0;
			pos_s1    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q     <= in_word;
						removed_q <= '0;
						status_q  <= STAT_OK;
						found_q   <= 1'b0;
						rd_pos_q  <= '0;
						val_s1    <= 1'b0;
						state_q   <= S_RESP;
						unique case (req_func)
							F_PUSH_FRONT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									head_q <= ptr_dec(head_q);
									cnt_q  <= cnt_q + CNT_W'(1);
								end
							end
							F_PUSH_BACK: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							F_POP_FRONT: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									head_q  <= ptr_add(head_q, CNT_W'(1));
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= S_POP;
								end
							end
							F_POP_BACK: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= S_POP;
								end
							end
							F_REMOVE: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					removed_q <= rd_data_q;
					state_q   <= S_RESP;
				end
				S_SCAN: begin
					if (mem_re) begin
						rd_pos_q <= rd_pos_q + CNT_W'(1);
					end
					val_s1 <= mem_re;
					pos_s1 <= rd_pos_q;
					if (match) begin
						found_q   <= 1'b1;
						removed_q <= rd_data_q;
					end
					if (last) begin
						if (found_q || match) begin
							cnt_q    <= cnt_q - CNT_W'(1);
							status_q <= STAT_OK;
						end else begin
							status_q <= STAT_NOTFOUND;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result
	assign req_ready           = (state_q == S_IDLE);
	assign res_valid           = (state_q == S_RESP);
	assign res.status          = status_q;
	assign res.removed_value   = to_port(removed_q);
	assign res.entry_count     = OCNT_W'(cnt_q);
	assign res.is_empty        = (cnt_q == '0);

endmodule

@@ design/deq_out_buf.sv @@
// output register between the sequencer and the result stream
`timescale 1ns / 1ps
module deq_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  deq_pkg::result_t in_res,
	output logic             out_valid,
	input  logic             out_ready,
	output deq_pkg::result_t out_res
);
	import deq_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// hold one result until the downstream takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			if (in_valid) begin
				res_q <= in_res;
			end
		end
	end

endmodule

@@ dv/deque_result_checker.sv @@
// result checker for the deque with remove-by-value: predicts each request and compares results
`timescale 1ns / 1ps
module deque_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // value [31:0]
	input  logic [2:0]  s_tuser,   // func [2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // status [1:0], removed_value [33:2],
	                               // entry_count [38:34], is_empty [39]
	output int unsigned mismatches,
	output int unsigned pending_results
);
	import deq_pkg::*;

	// shadow copy of the deque contents, front at index 0
	word_t   held_words[$];
	// results owed by the block, oldest first
	result_t owed_results[$];

	// apply one request to the shadow deque and return what the block must answer
	function automatic result_t apply_request(logic [FUNC_W-1:0] func, logic [VAL_W-1:0] value);
		result_t r;
		word_t   w;
		bit      found;
		w = value[WORD_BITS-1:0];
		r.status = STAT_OK;
		r.removed_value = '0;
		found = 1'b0;
		case (func)
			F_PUSH_FRONT: begin
				if (held_words.size() >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					held_words.push_front(w);
				end
			end
			F_PUSH_BACK: begin
				if (held_words.size() >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					held_words.push_back(w);
				end
			end
			F_POP_FRONT: begin
				if (held_words.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.removed_value = held_words.pop_front();
				end
			end
			F_POP_BACK: begin
				if (held_words.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.removed_value = held_words.pop_back();
				end
			end
			F_REMOVE: begin
				if (held_words.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					// first match from the front, others keep their order
					r.status = STAT_NOTFOUND;
					for (int i = 0; i < held_words.size() && !found; i++) begin
						if (held_words[i] == w) begin
							r.removed_value = held_words[i];
							held_words.delete(i);
							r.status = STAT_OK;
							found = 1'b1;
						end
					end
				end
			end
			default: begin
				// spare codes leave the deque alone
			end
		endcase
		r.entry_count = OCNT_W'(held_words.size());
		r.is_empty = (held_words.size() == 0);
		return r;
	endfunction

	// compare result transactions first, then log the request transaction of this edge
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		int unsigned errs;
		if (!arst_n) begin
			held_words.delete();
			owed_results.delete();
			mismatches <= 0;
			pending_results <= 0;
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, m_tdata);
					errs++;
				end else begin
					exp_r = owed_results.pop_front();
					if (m_tdata[1:0] !== exp_r.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							exp_r.status, m_tdata[1:0]);
						errs++;
					end
					if (m_tdata[33:2] !== exp_r.removed_value) begin
						$display("%0t: removed_value expected %h got %h", $time,
							exp_r.removed_value, m_tdata[33:2]);
						errs++;
					end
					if (m_tdata[38:34] !== exp_r.entry_count) begin
						$display("%0t: entry_count expected %0d got %0d", $time,
							exp_r.entry_count, m_tdata[38:34]);
						errs++;
					end
					if (m_tdata[39] !== exp_r.is_empty) begin
						$display("%0t: is_empty expected %0d got %0d", $time,
							exp_r.is_empty, m_tdata[39]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				owed_results.push_back(apply_request(s_tuser, s_tdata));
			end
			if (errs != 0) begin
				mismatches <= mismatches + 1;
			end
			pending_results <= owed_results.size();
		end
	end

endmodule

@@ dv/deque_with_remove_by_value_test.sv @@
// testbench top for the deque with remove-by-value: stimulus, result pacing and verdict
`timescale 1ns / 1ps
module deque_with_remove_by_value_test;
	import deq_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASE_ITEMS  = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 40;

	// codes the block does not use
	localparam logic [FUNC_W-1:0] F_SPARE_A = 3'd5;
	localparam logic [FUNC_W-1:0] F_SPARE_B = 3'd6;
	localparam logic [FUNC_W-1:0] F_SPARE_C = 3'd7;

	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	int unsigned mismatches;
	int unsigned pending_results;
	int unsigned idle_cycles;
	bit          hold_off_req;
	logic [31:0] value_pool[6];

	deque_with_remove_by_value dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	deque_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// request mix depends on whether the phase should fill or drain the deque
	function automatic logic [FUNC_W-1:0] pick_func(mix_t mix);
		int r;
		int push_lim;
		int pop_lim;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				push_lim = 55;
				pop_lim  = 70;
			end
			MIX_DRAIN: begin
				push_lim = 20;
				pop_lim  = 55;
			end
			default: begin
				push_lim = 40;
				pop_lim  = 65;
			end
		endcase
		if (r < push_lim) begin
			return $urandom_range(0, 1) ? F_PUSH_BACK : F_PUSH_FRONT;
		end else if (r < pop_lim) begin
			return $urandom_range(0, 1) ? F_POP_BACK : F_POP_FRONT;
		end else if (r < 95) begin
			return F_REMOVE;
		end
		case ($urandom_range(0, 2))
			0: return F_SPARE_A;
			1: return F_SPARE_B;
			default: return F_SPARE_C;
		endcase
	endfunction

	// small pool of words so that removes often find a match and duplicates occur
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 65) begin
			return value_pool[$urandom_range(0, 5)];
		end
		return $urandom();
	endfunction

	// offer one request transaction, wait for it to be taken, then idle for the given gap
	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [31:0] value,
			input int gap);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// watchdog on cycles without any transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int busy;
		int gap;
		bit hold_done;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				// stretch with no stalls
				busy = $urandom_range(50, 150);
				gap  = 0;
			end else begin
				busy = $urandom_range(1, 20);
				gap  = pick_gap();
			end
			repeat (busy) @(posedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// request side and verdict
	initial begin
		int unsigned sent;
		int          phase;
		mix_t        mix;
		bit          no_idle;
		logic [FUNC_W-1:0] func;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		hold_off_req = 1'b0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		value_pool[4] = $urandom();
		value_pool[5] = $urandom();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: pops and remove report empty
		send_request(F_POP_FRONT, 32'h0000_0001, 0);
		send_request(F_POP_BACK, 32'h8000_0000, 1);
		send_request(F_REMOVE, 32'h7FFF_FFFF, 0);
		// fill to the top from both ends with extreme and repeated words
		for (int i = 0; i < DEPTH; i++) begin
			send_request(i[0] ? F_PUSH_BACK : F_PUSH_FRONT, value_pool[i % 6], i % 3);
		end
		// full deque refuses pushes
		send_request(F_PUSH_FRONT, 32'h1234_5678, 0);
		send_request(F_PUSH_BACK, 32'hDEAD_BEEF, 2);
		// remove takes the first of several equal words, then a miss
		send_request(F_REMOVE, value_pool[0], 0);
		send_request(F_REMOVE, 32'h1234_5678, 0);
		send_request(F_POP_FRONT, 32'h0, 0);
		send_request(F_POP_BACK, 32'hFFFF_FFFF, 0);
		// spare codes only report the count
		send_request(F_SPARE_A, 32'hFFFF_FFFF, 0);
		send_request(F_SPARE_B, 32'h0, 0);
		send_request(F_SPARE_C, 32'hA5A5_5A5A, 3);

		// random phases, each leaning toward filling, draining or neither
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: mix = MIX_FILL;
				1: mix = MIX_DRAIN;
				default: mix = MIX_BALANCED;
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				hold_off_req = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS && sent < RANDOM_ITEMS; i++) begin
				func = pick_func(mix);
				send_request(func, pick_value(), no_idle ? 0 : pick_gap());
				sent++;
			end
			phase++;
		end

		// wait for every owed result, then let the block settle
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ deque_with_remove_by_value.f @@
design/deq_pkg.sv
design/deq_engine.sv
design/deq_out_buf.sv
design/deque_with_remove_by_value.sv
dv/deque_result_checker.sv
dv/deque_with_remove_by_value_test.sv
